// ===== hw/rtl/sgag_pkg.sv =====
`default_nettype none

package sgag_pkg;

   localparam int unsigned DimW       = 16;
   localparam int unsigned CountW     = 64;
   localparam int unsigned BaseW      = 32;
   localparam int unsigned SrcW       = 35;
   localparam int unsigned ActiveW    = 3;
   localparam int unsigned CsrDataW   = 64;
   localparam int unsigned CsrAddrW   = 5;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   typedef enum logic [1:0] {
      REG_ACTIVE_DIMS = 2'd0,
      REG_BASE_OFFSET = 2'd1,
      REG_DIM_SIZES   = 2'd2,
      REG_DIM_STRIDES = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CountW-1:0] dst_index;
      logic              last;
   } tag_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/strided_gather_address_generator_unit.sv =====
// Strided gather address generator. Each beat on the req_ channel asks for
// the next element of an N-dimensional strided view, walked in row-major
// order. Each request yields exactly one beat on the rsp_ channel with the
// source element offset, the destination element number and a last flag.
// Setting req_restart on a beat starts the walk over from the first element.
// The view is set up through the APB-style register port (active_dims,
// base_offset, dim_sizes, dim_strides at byte addresses 0, 8, 16 and 24).
// It must be written only while no request is in flight; the block itself
// does not enforce this. An accepted request is written into the queue,
// then passes the product and sum registers on its way to the rsp_ channel.
// The odometer advances once per accepted beat, so while rsp_stall stays
// low one request and one response can be taken every cycle. A four-entry
// queue separates the odometer from the multiply and sum pipeline behind it.
// While rsp_stall is high the response and the pipeline hold, the queue
// fills, and req_stall rises once the queue is full. Reset clears the
// indices, the element count, the pipeline valid bits, the queue pointers
// and every config register but dim_sizes, which sets each size to one.
`default_nettype none

module strided_gather_address_generator_unit #(
   parameter int unsigned MAX_DIMS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_restart,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [sgag_pkg::SrcW-1:0]               rsp_src_addr,
   output logic [sgag_pkg::CountW-1:0]             rsp_dst_index,
   output logic                                    rsp_last,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [sgag_pkg::CsrAddrW-1:0]      paddr,
   input  wire logic [sgag_pkg::CsrDataW-1:0]      pwdata,
   output logic [sgag_pkg::CsrDataW-1:0]           prdata,
   output logic                                    pready
);

   localparam int unsigned IdxVecW = MAX_DIMS * sgag_pkg::DimW;
   localparam int unsigned TagW    = $bits(sgag_pkg::tag_type);
   localparam int unsigned EntryW  = IdxVecW + TagW;

   logic [sgag_pkg::ActiveW-1:0]  active_dims_ff;
   logic [sgag_pkg::BaseW-1:0]    base_offset_ff;
   logic [4*sgag_pkg::DimW-1:0]   dim_sizes_ff;
   logic [4*sgag_pkg::DimW-1:0]   dim_strides_ff;
   sgag_pkg::reg_index_type       reg_sel;
   logic                          csr_write;

   sgag_pkg::queue_status_type    q_status;
   logic                          q_push;
   logic                          q_pop;
   logic [IdxVecW-1:0]            push_idx;
   sgag_pkg::tag_type             push_tag;
   logic [EntryW-1:0]             pop_entry;
   logic [IdxVecW-1:0]            pop_idx;
   sgag_pkg::tag_type             pop_tag;

   assign pready    = 1'b1;
   assign reg_sel   = sgag_pkg::reg_index_type'(paddr[4:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_dims_ff <= '0;
         base_offset_ff <= '0;
         dim_sizes_ff   <= 64'h0001_0001_0001_0001;
         dim_strides_ff <= '0;
      end else if (csr_write) begin
         case (reg_sel)
            sgag_pkg::REG_ACTIVE_DIMS: begin
               active_dims_ff <= pwdata[sgag_pkg::ActiveW-1:0];
            end
            sgag_pkg::REG_BASE_OFFSET: begin
               base_offset_ff <= pwdata[sgag_pkg::BaseW-1:0];
            end
            sgag_pkg::REG_DIM_SIZES: begin
               dim_sizes_ff <= pwdata;
            end
            sgag_pkg::REG_DIM_STRIDES: begin
               dim_strides_ff <= pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         sgag_pkg::REG_ACTIVE_DIMS: prdata = sgag_pkg::CsrDataW'(active_dims_ff);
         sgag_pkg::REG_BASE_OFFSET: prdata = sgag_pkg::CsrDataW'(base_offset_ff);
         sgag_pkg::REG_DIM_SIZES:   prdata = dim_sizes_ff;
         sgag_pkg::REG_DIM_STRIDES: prdata = dim_strides_ff;
         default:                   prdata = '0;
      endcase
   end

   sgag_front #(
      .MAX_DIMS (MAX_DIMS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .active_dims (active_dims_ff),
      .dim_sizes   (dim_sizes_ff),
      .q_status    (q_status),
      .q_push      (q_push),
      .push_idx    (push_idx),
      .push_tag    (push_tag)
   );

   sgag_queue #(
      .WIDTH (EntryW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_idx, push_tag}),
      .pop       (q_pop),
      .pop_data  (pop_entry),
      .status    (q_status)
   );

   assign pop_idx = pop_entry[EntryW-1 -: IdxVecW];
   assign pop_tag = sgag_pkg::tag_type'(pop_entry[TagW-1:0]);

   sgag_back #(
      .MAX_DIMS (MAX_DIMS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_idx          (pop_idx),
      .q_tag          (pop_tag),
      .q_pop          (q_pop),
      .base_offset    (base_offset_ff),
      .dim_strides    (dim_strides_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_src_addr   (rsp_src_addr),
      .rsp_dst_index  (rsp_dst_index),
      .rsp_last       (rsp_last)
   );

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("Queue popped while empty.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("Queue pushed while full.");

   a_single_element_view: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (active_dims_ff == '0)) |-> rsp_last)
      else $error("A view without dimensions produced an element that is not last.");

endmodule

`default_nettype wire

// ===== hw/rtl/sgag_front.sv =====
`default_nettype none

module sgag_front #(
   parameter int unsigned MAX_DIMS = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_restart,
   output logic                                       req_stall,
   input  wire logic [sgag_pkg::ActiveW-1:0]          active_dims,
   input  wire logic [4*sgag_pkg::DimW-1:0]           dim_sizes,
   input  wire sgag_pkg::queue_status_type            q_status,
   output logic                                       q_push,
   output logic [MAX_DIMS*sgag_pkg::DimW-1:0]         push_idx,
   output sgag_pkg::tag_type                          push_tag
);

   localparam logic [sgag_pkg::ActiveW-1:0] MaxDimsCode = sgag_pkg::ActiveW'(MAX_DIMS);

   logic [sgag_pkg::DimW-1:0]   idx_ff [MAX_DIMS];
   logic [sgag_pkg::DimW-1:0]   idx_in [MAX_DIMS];
   logic [sgag_pkg::DimW-1:0]   cur_idx [MAX_DIMS];
   logic [sgag_pkg::DimW-1:0]   size_eff [MAX_DIMS];
   logic                        wrap [MAX_DIMS];
   logic                        dim_on [MAX_DIMS];
   logic                        carry [MAX_DIMS+1];
   logic [sgag_pkg::CountW-1:0] count_ff;
   logic [sgag_pkg::CountW-1:0] count_in;
   logic [sgag_pkg::CountW-1:0] cur_count;
   logic [sgag_pkg::ActiveW-1:0] dims_used;
   logic                        accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept;
   assign dims_used = (active_dims > MaxDimsCode) ? MaxDimsCode : active_dims;
   assign cur_count = req_restart ? '0 : count_ff;

   always_comb begin
      carry[MAX_DIMS] = 1'b1;
      for (int k = MAX_DIMS - 1; k >= 0; k--) begin
         cur_idx[k]  = req_restart ? '0 : idx_ff[k];
         size_eff[k] = (dim_sizes[k*sgag_pkg::DimW +: sgag_pkg::DimW] == '0) ?
                       sgag_pkg::DimW'(1) : dim_sizes[k*sgag_pkg::DimW +: sgag_pkg::DimW];
         dim_on[k]   = sgag_pkg::ActiveW'(k) < dims_used;
         wrap[k]     = ({1'b0, cur_idx[k]} + 17'd1) >= {1'b0, size_eff[k]};
         if (dim_on[k] && carry[k+1]) begin
            idx_in[k] = wrap[k] ? '0 : cur_idx[k] + sgag_pkg::DimW'(1);
            carry[k]  = wrap[k];
         end else begin
            idx_in[k] = cur_idx[k];
            carry[k]  = carry[k+1];
         end
         push_idx[k*sgag_pkg::DimW +: sgag_pkg::DimW] = dim_on[k] ? cur_idx[k] : '0;
      end
   end

   assign push_tag.dst_index = cur_count;
   assign push_tag.last      = carry[0];
   assign count_in           = carry[0] ? '0 : cur_count + sgag_pkg::CountW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_DIMS; k++) begin
            idx_ff[k] <= '0;
         end
         count_ff <= '0;
      end else if (accept) begin
         for (int k = 0; k < MAX_DIMS; k++) begin
            idx_ff[k] <= idx_in[k];
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sgag_queue.sv =====
`default_nettype none

module sgag_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output sgag_pkg::queue_status_type      status
);

   logic [WIDTH-1:0]                 mem_ff [sgag_pkg::QueueDepth];
   logic [sgag_pkg::QueuePtrW-1:0]   wr_ptr_ff;
   logic [sgag_pkg::QueuePtrW-1:0]   rd_ptr_ff;
   logic [sgag_pkg::QueuePtrW:0]     fill_ff;
   logic [sgag_pkg::QueuePtrW:0]     fill_in;

   assign status.full  = fill_ff == (sgag_pkg::QueuePtrW+1)'(sgag_pkg::QueueDepth);
   assign status.empty = fill_ff == '0;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (sgag_pkg::QueuePtrW+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (sgag_pkg::QueuePtrW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + sgag_pkg::QueuePtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + sgag_pkg::QueuePtrW'(1);
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sgag_back.sv =====
`default_nettype none

module sgag_back #(
   parameter int unsigned MAX_DIMS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sgag_pkg::queue_status_type          q_status,
   input  wire logic [MAX_DIMS*sgag_pkg::DimW-1:0]  q_idx,
   input  wire sgag_pkg::tag_type                   q_tag,
   output logic                                     q_pop,
   input  wire logic [sgag_pkg::BaseW-1:0]          base_offset,
   input  wire logic [4*sgag_pkg::DimW-1:0]         dim_strides,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [sgag_pkg::SrcW-1:0]                rsp_src_addr,
   output logic [sgag_pkg::CountW-1:0]              rsp_dst_index,
   output logic                                     rsp_last
);

   localparam int unsigned ProdW = 2 * sgag_pkg::DimW;

   logic                        a_valid_ff;
   logic [ProdW-1:0]            prod_ff [MAX_DIMS];
   sgag_pkg::tag_type           a_tag_ff;
   logic                        b_valid_ff;
   logic [sgag_pkg::SrcW-1:0]   src_ff;
   logic [sgag_pkg::SrcW-1:0]   src_in;
   sgag_pkg::tag_type           b_tag_ff;
   logic                        a_adv;
   logic                        b_adv;

   assign b_adv = !b_valid_ff || !rsp_stall;
   assign a_adv = !a_valid_ff || b_adv;
   assign q_pop = !q_status.empty && a_adv;

   always_comb begin
      src_in = sgag_pkg::SrcW'(base_offset);
      for (int k = 0; k < MAX_DIMS; k++) begin
         src_in = src_in + sgag_pkg::SrcW'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= q_pop;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int k = 0; k < MAX_DIMS; k++) begin
            prod_ff[k] <= q_idx[k*sgag_pkg::DimW +: sgag_pkg::DimW] *
                          dim_strides[k*sgag_pkg::DimW +: sgag_pkg::DimW];
         end
         a_tag_ff <= q_tag;
      end
      if (b_adv && a_valid_ff) begin
         src_ff   <= src_in;
         b_tag_ff <= a_tag_ff;
      end
   end

   assign rsp_valid      = b_valid_ff;
   assign rsp_src_addr   = src_ff;
   assign rsp_dst_index  = b_tag_ff.dst_index;
   assign rsp_last       = b_tag_ff.last;

endmodule

`default_nettype wire
